// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/cct_pkg.sv
// ---------------------------------------------------------------------------
// cct_pkg
// constants and types of the cycle counter time split block
// ---------------------------------------------------------------------------
package cct_pkg;

    localparam int CNT_BITS  = 32;                      // used bits of a counter sample
    localparam int WRAP_BITS = 32;
    localparam int TICK_BITS = 64;
    localparam int CPU_BITS  = 10;                      // cycles per microsecond register
    localparam int SEC_BITS  = 45;
    localparam int SUB_BITS  = 10;                      // milliseconds and microseconds
    localparam int STEP_BITS = $clog2(TICK_BITS + 1);

    localparam logic [SUB_BITS:0] US_PER_MS = (SUB_BITS + 1)'(1000);

    typedef struct packed {
        logic busy;
        logic done;
    } cct_div_stat_t;

endpackage

// File: sv/cct_div_chain.sv
// ---------------------------------------------------------------------------
// cct_div_chain
// bit-serial long division by the clock rate, cascaded into two divisions
// by 1000; quotient bits stream msb first from one stage into the next
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cct_div_chain (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [cct_pkg::TICK_BITS-1:0]    dividend,
    input  logic [cct_pkg::CPU_BITS-1:0]     divisor,
    output cct_pkg::cct_div_stat_t           stat,
    output logic [cct_pkg::SEC_BITS-1:0]     seconds,
    output logic [cct_pkg::SUB_BITS-1:0]     milliseconds,
    output logic [cct_pkg::SUB_BITS-1:0]     microseconds
);
    import cct_pkg::*;

    logic [TICK_BITS-1:0] dvd_reg,   dvd_next;
    logic [CPU_BITS-1:0]  div_reg,   div_next;
    logic [CPU_BITS-1:0]  rem_a_reg, rem_a_next;
    logic [SUB_BITS-1:0]  rem_b_reg, rem_b_next;
    logic [SUB_BITS-1:0]  rem_c_reg, rem_c_next;
    logic [SEC_BITS-1:0]  sec_reg,   sec_next;
    logic [STEP_BITS-1:0] cnt_reg,   cnt_next;
    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;

    logic [CPU_BITS:0]    sh_a;
    logic [SUB_BITS:0]    sh_b;
    logic [SUB_BITS:0]    sh_c;
    logic                 q_a;
    logic                 q_b;
    logic                 q_c;

    // one restoring step per stage, chained in the same cycle
    always_comb
    begin
        sh_a = {rem_a_reg, dvd_reg[TICK_BITS-1]};
        q_a  = (sh_a >= {1'b0, div_reg});
        sh_b = {rem_b_reg, q_a};
        q_b  = (sh_b >= US_PER_MS);
        sh_c = {rem_c_reg, q_b};
        q_c  = (sh_c >= US_PER_MS);
    end

    always_comb
    begin
        dvd_next   = dvd_reg;
        div_next   = div_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        rem_c_next = rem_c_reg;
        sec_next   = sec_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            dvd_next   = dividend;
            div_next   = divisor;
            rem_a_next = '0;
            rem_b_next = '0;
            rem_c_next = '0;
            sec_next   = '0;
            cnt_next   = STEP_BITS'(TICK_BITS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next   = {dvd_reg[TICK_BITS-2:0], 1'b0};
            rem_a_next = CPU_BITS'(q_a ? (sh_a - {1'b0, div_reg}) : sh_a);
            rem_b_next = SUB_BITS'(q_b ? (sh_b - US_PER_MS) : sh_b);
            rem_c_next = SUB_BITS'(q_c ? (sh_c - US_PER_MS) : sh_c);
            sec_next   = {sec_reg[SEC_BITS-2:0], q_c};
            cnt_next   = cnt_reg - STEP_BITS'(1);
            if (cnt_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        div_reg   <= div_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
        rem_c_reg <= rem_c_next;
        sec_reg   <= sec_next;
    end

    assign stat.busy    = busy_reg;
    assign stat.done    = done_reg;
    assign seconds      = sec_reg;
    assign milliseconds = rem_c_reg;
    assign microseconds = rem_b_reg;

    `AST_NEXT(a_start_busy, start, busy_reg && cnt_reg == STEP_BITS'(TICK_BITS))
    `AST_NEXT(a_last_done, busy_reg && !start && cnt_reg == STEP_BITS'(1), done_reg && !busy_reg)
    `AST_SAME(a_done_range, done_reg, rem_b_reg < US_PER_MS && rem_c_reg < US_PER_MS)

endmodule

// File: sv/cycle_counter_time_split.sv
// ---------------------------------------------------------------------------
// cycle_counter_time_split
// extends counter samples to 64-bit ticks and splits ticks / clock rate
// into seconds, milliseconds and microseconds
// a sample is taken only in the idle state, runs through the bit-serial
// divider chain and waits there until the output register is free; the
// result then waits in the output register while a new sample is taken
// reset: wrap count and previous sample clear, the cycles-per-us register returns to 1
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cycle_counter_time_split (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cct_pkg::CPU_BITS-1:0]     cycles_per_us,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [31:0]                      counter_sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cct_pkg::TICK_BITS-1:0]    total_ticks,
    output logic [cct_pkg::SEC_BITS-1:0]     seconds,
    output logic [cct_pkg::SUB_BITS-1:0]     milliseconds,
    output logic [cct_pkg::SUB_BITS-1:0]     microseconds
);
    import cct_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_WAIT
    } state_t;

    state_t               state_reg, state_next;
    logic [CPU_BITS-1:0]  cpu_reg,   cpu_next;
    logic [CNT_BITS-1:0]  prev_reg,  prev_next;
    logic [WRAP_BITS-1:0] wrap_reg,  wrap_next;
    logic [TICK_BITS-1:0] ticks_reg, ticks_next;
    logic                 ov_reg,    ov_next;
    logic [TICK_BITS-1:0] ot_reg,    ot_next;
    logic [SEC_BITS-1:0]  os_reg,    os_next;
    logic [SUB_BITS-1:0]  oms_reg,   oms_next;
    logic [SUB_BITS-1:0]  ous_reg,   ous_next;

    logic                 in_acc;
    logic                 out_free;
    logic                 load_out;
    logic [CNT_BITS-1:0]  sample;
    logic [CPU_BITS-1:0]  div_eff;
    cct_div_stat_t        div_stat;
    logic [SEC_BITS-1:0]  d_sec;
    logic [SUB_BITS-1:0]  d_ms;
    logic [SUB_BITS-1:0]  d_us;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !ov_reg || out_ready;
    assign sample    = counter_sample[CNT_BITS-1:0];
    // a zero rate divides as one
    assign div_eff   = (cpu_reg == '0) ? CPU_BITS'(1) : cpu_reg;

    cct_div_chain u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_acc),
        .dividend     (ticks_next),
        .divisor      (div_eff),
        .stat         (div_stat),
        .seconds      (d_sec),
        .milliseconds (d_ms),
        .microseconds (d_us)
    );

    always_comb
    begin
        state_next = state_reg;
        cpu_next   = cpu_reg;
        prev_next  = prev_reg;
        wrap_next  = wrap_reg;
        ticks_next = ticks_reg;
        load_out   = 1'b0;
        if (cfg_valid && cfg_ready)
            cpu_next = cycles_per_us;
        if (in_acc)
        begin
            // an equal sample is not a wrap
            if (sample < prev_reg)
                wrap_next = wrap_reg + WRAP_BITS'(1);
            prev_next  = sample;
            ticks_next = (TICK_BITS'(wrap_next) << CNT_BITS) + TICK_BITS'(sample);
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                if (div_stat.done)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next  = ov_reg;
        ot_next  = ot_reg;
        os_next  = os_reg;
        oms_next = oms_reg;
        ous_next = ous_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (load_out)
        begin
            ov_next  = 1'b1;
            ot_next  = ticks_reg;
            os_next  = d_sec;
            oms_next = d_ms;
            ous_next = d_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cpu_reg   <= CPU_BITS'(1);
            prev_reg  <= '0;
            wrap_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cpu_reg   <= cpu_next;
            prev_reg  <= prev_next;
            wrap_reg  <= wrap_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ticks_reg <= ticks_next;
        ot_reg    <= ot_next;
        os_reg    <= os_next;
        oms_reg   <= oms_next;
        ous_reg   <= ous_next;
    end

    assign out_valid    = ov_reg;
    assign total_ticks  = ot_reg;
    assign seconds      = os_reg;
    assign milliseconds = oms_reg;
    assign microseconds = ous_reg;

    `AST_NEXT(a_accept_calc, in_acc, state_reg == S_CALC && div_stat.busy)
    `AST_SAME(a_done_in_calc, div_stat.done, state_reg == S_CALC)
    `AST_NEXT(a_load_valid, load_out, ov_reg && state_reg == S_IDLE)

endmodule

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// checks cycle_counter_time_split against a local time-split predictor:
// counter samples are streamed with random gaps and output stalls, and
// each accepted result is compared field by field with the prediction
// ---------------------------------------------------------------------------
module tb_top;

    import cct_pkg::*;

    localparam longint unsigned USEC_PER_SEC  = 1000000;
    localparam longint unsigned USEC_PER_MSEC = 1000;
    localparam int              CYCLE_LIMIT   = 500000;
    localparam int              TAIL_CYCLES   = 80;
    localparam int              RANDOM_PHASES = 10;
    localparam int              PHASE_ITEMS   = 68;

    typedef struct packed {
        logic [TICK_BITS-1:0] ticks;
        logic [SEC_BITS-1:0]  sec;
        logic [SUB_BITS-1:0]  msec;
        logic [SUB_BITS-1:0]  usec;
    } time_split_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CPU_BITS-1:0]  cycles_per_us;
    logic                 in_valid;
    logic                 in_ready;
    logic [31:0]          counter_sample;
    logic                 out_valid;
    logic                 out_ready;
    logic [TICK_BITS-1:0] total_ticks;
    logic [SEC_BITS-1:0]  seconds;
    logic [SUB_BITS-1:0]  milliseconds;
    logic [SUB_BITS-1:0]  microseconds;

    // predictor state
    logic [CPU_BITS-1:0]  clock_mhz = CPU_BITS'(1);
    logic [31:0]          last_sample = '0;
    logic [31:0]          wrap_total = '0;

    logic [31:0]          pending_samples[$];
    time_split_t          expected_splits[$];
    logic [31:0]          counter_now = '0;

    int                   gap_max = 0;
    int                   stall_max = 0;
    int                   in_gap = 0;
    int                   out_stall = 0;
    logic                 in_taken = 1'b0;
    logic                 out_taken = 1'b0;
    int                   error_count = 0;
    int                   cycle_count = 0;

    cycle_counter_time_split dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cycles_per_us  (cycles_per_us),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .counter_sample (counter_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .total_ticks    (total_ticks),
        .seconds        (seconds),
        .milliseconds   (milliseconds),
        .microseconds   (microseconds)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // extends one sample and splits ticks / clock rate into s, ms, us
    function automatic time_split_t split_time(logic [31:0] sample);
        time_split_t          r;
        logic [TICK_BITS-1:0] divisor;
        logic [TICK_BITS-1:0] usec_total;
        if (sample < last_sample)
            wrap_total = wrap_total + 1;
        last_sample = sample;
        r.ticks    = {wrap_total, sample};
        divisor    = (clock_mhz == 0) ? TICK_BITS'(1) : TICK_BITS'(clock_mhz);
        usec_total = r.ticks / divisor;
        r.sec      = SEC_BITS'(usec_total / USEC_PER_SEC);
        r.msec     = SUB_BITS'((usec_total % USEC_PER_SEC) / USEC_PER_MSEC);
        r.usec     = SUB_BITS'(usec_total % USEC_PER_MSEC);
        return r;
    endfunction

    // mostly a counter running forward, with repeats, wraps and noise
    function automatic logic [31:0] next_reading();
        case ($urandom_range(0, 15))
            0: ;
            1: counter_now = $urandom;
            2: counter_now = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            3: counter_now = $urandom_range(0, 1000);
            4, 5: counter_now = counter_now + $urandom;
            default: counter_now = counter_now + $urandom_range(1, 1 << 24);
        endcase
        return counter_now;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || in_valid || expected_splits.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_rate(logic [CPU_BITS-1:0] value);
        @(negedge clk);
        cycles_per_us <= value;
        cfg_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // sender: one item per handshake, random gap after each
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
                ;
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (pending_samples.size() != 0)
            begin
                counter_sample <= pending_samples.pop_front();
                in_valid       <= 1'b1;
                in_gap         <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stall before each result
    always @(negedge clk)
    begin
        int n;
        if (rst_n)
        begin
            if (out_taken && stall_max > 0)
            begin
                n = $urandom_range(0, stall_max);
                out_ready <= (n == 0);
                out_stall <= (n == 0) ? 0 : n - 1;
            end
            else if (out_stall > 0)
            begin
                out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        time_split_t want;
        if (rst_n)
        begin
            in_taken  <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (cfg_valid && cfg_ready)
                clock_mhz = cycles_per_us;
            if (in_valid && in_ready)
                expected_splits.push_back(split_time(counter_sample));
            if (out_valid && out_ready)
            begin
                if (expected_splits.size() == 0)
                    report_mismatch("unexpected item, total_ticks", total_ticks, 64'(0));
                else
                begin
                    want = expected_splits.pop_front();
                    if (total_ticks !== want.ticks)
                        report_mismatch("total_ticks", total_ticks, want.ticks);
                    if (seconds !== want.sec)
                        report_mismatch("seconds", 64'(seconds), 64'(want.sec));
                    if (milliseconds !== want.msec)
                        report_mismatch("milliseconds", 64'(milliseconds), 64'(want.msec));
                    if (microseconds !== want.usec)
                        report_mismatch("microseconds", 64'(microseconds), 64'(want.usec));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [CPU_BITS-1:0] rate;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cycles_per_us  = '0;
        in_valid       = 1'b0;
        counter_sample = '0;
        out_ready      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, repeats and wraps at rate 1
        write_rate(CPU_BITS'(1));
        pending_samples = '{32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'd999999, 32'd1000000};
        wait_idle();

        // zero rate acts as one
        write_rate(CPU_BITS'(0));
        gap_max   = 16;
        stall_max = 16;
        pending_samples = '{32'hFFFF_FFFF, 32'd5, 32'd1000};
        wait_idle();

        write_rate(CPU_BITS'(1000));
        pending_samples = '{32'd0, 32'd999, 32'd1000, 32'hFFFF_FFFF, 32'd1};
        wait_idle();

        write_rate(CPU_BITS'(1023));
        gap_max   = 0;
        stall_max = 0;
        pending_samples = '{32'hFFFF_FFFF, 32'd0, 32'd1023};
        wait_idle();

        counter_now = last_sample;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 5))
                0: rate = CPU_BITS'(0);
                1: rate = CPU_BITS'(1);
                2: rate = CPU_BITS'(1000);
                3: rate = CPU_BITS'(1023);
                default: rate = CPU_BITS'($urandom_range(1, 1000));
            endcase
            write_rate(rate);
            gap_max   = (p % 3 == 0) ? 0 : 16;
            stall_max = (p % 4 == 1) ? 0 : 16;
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_samples.push_back(next_reading());
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
